@@ hdl/battery_voltage_smoother_level_gauge_core_assert.svh @@
// assertion macros for the battery voltage smoother checker
// no dependencies; every macro samples on clk and is disabled during rst
`ifndef BATTERY_VOLTAGE_SMOOTHER_LEVEL_GAUGE_CORE_ASSERT_SVH
`define BATTERY_VOLTAGE_SMOOTHER_LEVEL_GAUGE_CORE_ASSERT_SVH

// same-cycle implication
`define BVSLG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bvslg assertion failed");

// next-cycle implication
`define BVSLG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bvslg assertion failed");

`endif

@@ hdl/bvslg_pkg.sv @@
// shared widths, register indexes, reset values and level search for the
// battery voltage smoother and level gauge; no dependencies
package bvslg_pkg;

  localparam int VoltW  = 16;
  localparam int OffW   = 13;
  localparam int LevelW = 3;
  localparam int IdxW   = 3;
  localparam int TermW  = 14;  // floor(v/100)*20 stays below 13108

  // register indexes
  localparam logic [IdxW-1:0] REG_THR_ONE   = 3'd0;
  localparam logic [IdxW-1:0] REG_THR_TWO   = 3'd1;
  localparam logic [IdxW-1:0] REG_THR_THREE = 3'd2;
  localparam logic [IdxW-1:0] REG_THR_FOUR  = 3'd3;
  localparam logic [IdxW-1:0] REG_HYST      = 3'd4;
  localparam logic [IdxW-1:0] REG_INIT_VOLT = 3'd5;

  localparam logic [VoltW-1:0] RST_THR_ONE   = 16'd42000;
  localparam logic [VoltW-1:0] RST_THR_TWO   = 16'd44000;
  localparam logic [VoltW-1:0] RST_THR_THREE = 16'd46000;
  localparam logic [VoltW-1:0] RST_THR_FOUR  = 16'd48000;
  localparam logic [OffW-1:0]  RST_HYST      = 13'd500;
  localparam logic [VoltW-1:0] RST_INIT_VOLT = 16'd40000;

  localparam logic [LevelW-1:0] LEVEL_MAX = 3'd4;

  // floor(q/25) = (q*20972) >> 19 for q < 16384
  localparam logic [14:0] RECIP_25 = 15'd20972;
  // floor(x/5) = (x*52429) >> 18 for x < 262144
  localparam logic [15:0] RECIP_5  = 16'd52429;

  function automatic logic [VoltW-1:0] sat_add(input logic [VoltW-1:0] a,
                                               input logic [OffW-1:0] b);
    logic [VoltW:0] s;
    s = {1'b0, a} + {4'b0, b};
    return s[VoltW] ? {VoltW{1'b1}} : s[VoltW-1:0];
  endfunction

  // index of first threshold+extra that s is below, max level if none
  function automatic logic [LevelW-1:0] find_level(input logic [VoltW-1:0] s,
                                                   input logic [VoltW-1:0] t1,
                                                   input logic [VoltW-1:0] t2,
                                                   input logic [VoltW-1:0] t3,
                                                   input logic [VoltW-1:0] t4,
                                                   input logic [OffW-1:0] extra);
    logic [LevelW-1:0] lvl;
    priority if (s < sat_add(t1, extra)) lvl = 3'd0;
    else if (s < sat_add(t2, extra)) lvl = 3'd1;
    else if (s < sat_add(t3, extra)) lvl = 3'd2;
    else if (s < sat_add(t4, extra)) lvl = 3'd3;
    else lvl = LEVEL_MAX;
    return lvl;
  endfunction

endpackage

@@ hdl/battery_voltage_smoother_level_gauge_core.sv @@
// battery voltage smoother and level gauge, top level
// depends on bvslg_pkg

// One voltage sample is taken per clock while in_stall is low, and each
// sample yields one result (smoothed voltage and charge level 0..4). Each result
// is registered after the first stage, as soon as the output register is free.
// The first stage scales the sample to floor(v/100)*20 with a reciprocal
// multiply; the second stage closes the smoothing feedback loop
// (floor(4s/5) by reciprocal multiply, saturating add, threshold compares
// with and without hysteresis) combinationally, holding the throughput at one
// sample per clock while out_stall is low. While the output register waits for
// the downstream side the first stage holds one more sample, then stalls. Writing
// initial_voltage reloads the smoothed value immediately; the level is kept.
module battery_voltage_smoother_level_gauge_core
  import bvslg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [IdxW-1:0]   cfg_index,
  input  logic [VoltW-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [VoltW-1:0]  voltage_sample,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [VoltW-1:0]  smoothed_voltage,
  output logic [LevelW-1:0] charge_level
);

  logic [VoltW-1:0]  thr_one, thr_two, thr_three, thr_four;
  logic [OffW-1:0]   hyst;
  logic [VoltW-1:0]  smooth_value, smooth_next;
  logic [LevelW-1:0] level_now, level_next;

  logic              stage_valid;
  logic [TermW-1:0]  term;
  logic [TermW-1:0]  term_next;
  logic [28:0]       quot_prod;
  logic [33:0]       scale_prod;
  logic [VoltW:0]    sum;
  logic [LevelW-1:0] up_level, dn_level;
  logic              in_xfer, advance;

  assign advance  = stage_valid && (!out_valid || !out_stall);
  assign in_stall = stage_valid && !advance;
  assign in_xfer  = in_valid && !in_stall;

  // floor(v/100) = floor(floor(v/4)/25), then times 20
  assign quot_prod = {1'b0, voltage_sample[VoltW-1:2]} * RECIP_25;
  assign term_next = TermW'({4'b0, quot_prod[28:19]} * 14'd20);

  // floor(s*80/100) = floor(4s/5)
  assign scale_prod = {smooth_value, 2'b00} * RECIP_5;
  assign sum = {1'b0, scale_prod[33:18]} + {3'b0, term};
  assign smooth_next = sum[VoltW] ? {VoltW{1'b1}} : sum[VoltW-1:0];

  assign up_level = find_level(smooth_next, thr_one, thr_two, thr_three, thr_four, hyst);
  assign dn_level = find_level(smooth_next, thr_one, thr_two, thr_three, thr_four, '0);

  always_comb begin
    priority if (up_level > level_now) level_next = up_level;
    else if (dn_level < level_now) level_next = dn_level;
    else level_next = level_now;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr_one   <= RST_THR_ONE;
      thr_two   <= RST_THR_TWO;
      thr_three <= RST_THR_THREE;
      thr_four  <= RST_THR_FOUR;
      hyst      <= RST_HYST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_THR_ONE:   thr_one   <= cfg_data;
        REG_THR_TWO:   thr_two   <= cfg_data;
        REG_THR_THREE: thr_three <= cfg_data;
        REG_THR_FOUR:  thr_four  <= cfg_data;
        REG_HYST:      hyst      <= cfg_data[OffW-1:0];
        // initial_voltage only reloads the smoothed value below
        REG_INIT_VOLT: ;
        default: ;
      endcase
    end
  end

  // smoothing and level state
  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_value <= RST_INIT_VOLT;
      level_now    <= '0;
    end else if (cfg_write && cfg_index == REG_INIT_VOLT) begin
      smooth_value <= cfg_data;
    end else if (advance) begin
      smooth_value <= smooth_next;
      level_now    <= level_next;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_xfer) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      term <= term_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      smoothed_voltage <= smooth_next;
      charge_level     <= level_next;
    end
  end

endmodule

@@ hdl/bvslg_checker.sv @@
// port-level checker for the battery voltage smoother and level gauge
// depends on bvslg_pkg and the assertion macro header; bound to the top level
`include "battery_voltage_smoother_level_gauge_core_assert.svh"

module bvslg_checker
  import bvslg_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [VoltW-1:0]  smoothed_voltage,
  input logic [LevelW-1:0] charge_level
);

  // a stalled result stays offered
  `BVSLG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // a stalled result does not change
  `BVSLG_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
                     $stable(smoothed_voltage) && $stable(charge_level))

  // level never passes full
  `BVSLG_ASSERT_NOW(a_level_range, out_valid, charge_level <= LEVEL_MAX)

  // every accepted sample is followed by a valid result on the output
  `BVSLG_ASSERT_NEXT(a_latency, in_valid && !in_stall, ##1 out_valid)

endmodule

bind battery_voltage_smoother_level_gauge_core bvslg_checker u_bvslg_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .smoothed_voltage (smoothed_voltage),
  .charge_level     (charge_level)
);

@@ verif/bvslg_tb_pkg.sv @@
`timescale 1ns / 100ps
// scoreboard for the battery voltage smoother testbench: a cycle-free model of
// the smoothing and level logic and the queue of readings the block still owes
// depends on bvslg_pkg
package bvslg_tb_pkg;
  import bvslg_pkg::*;

  // indexes past the last register, writes there must change nothing
  localparam logic [IdxW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IdxW-1:0] REG_SPARE_HI = 3'd7;
  localparam int VOLT_CEIL = 65535;

  typedef struct packed {
    logic [VoltW-1:0]  volts;
    logic [LevelW-1:0] level;
  } gauge_reading_t;

  class level_gauge_checker;
    logic [VoltW-1:0]  thr [4];
    logic [OffW-1:0]   hyst;
    logic [VoltW-1:0]  smooth;
    logic [LevelW-1:0] level;
    gauge_reading_t    pending_readings [$];
    int                mismatches;

    function new();
      thr[0]     = RST_THR_ONE;
      thr[1]     = RST_THR_TWO;
      thr[2]     = RST_THR_THREE;
      thr[3]     = RST_THR_FOUR;
      hyst       = RST_HYST;
      smooth     = RST_INIT_VOLT;
      level      = '0;
      mismatches = 0;
    endfunction

    function void apply_reg(logic [IdxW-1:0] idx, logic [VoltW-1:0] data);
      case (idx)
        REG_THR_ONE:   thr[0] = data;
        REG_THR_TWO:   thr[1] = data;
        REG_THR_THREE: thr[2] = data;
        REG_THR_FOUR:  thr[3] = data;
        REG_HYST:      hyst = data[OffW-1:0];
        REG_INIT_VOLT: smooth = data;  // reload, level stays
        default: ;
      endcase
    endfunction

    // first threshold (plus extra, clamped) that s sits below, full if none
    function int rank_of(int s, int extra);
      int bound;
      for (int k = 0; k < 4; k++) begin
        bound = int'(thr[k]) + extra;
        if (bound > VOLT_CEIL) bound = VOLT_CEIL;
        if (s < bound) return k;
      end
      return int'(LEVEL_MAX);
    endfunction

    function void note_sample(logic [VoltW-1:0] v);
      int s;
      int up;
      int dn;
      gauge_reading_t r;
      s = int'(smooth) * 80 / 100 + (int'(v) / 100) * 20;
      if (s > VOLT_CEIL) s = VOLT_CEIL;
      smooth = s[VoltW-1:0];
      up = rank_of(s, int'(hyst));
      dn = rank_of(s, 0);
      if (up > int'(level)) level = up[LevelW-1:0];
      else if (dn < int'(level)) level = dn[LevelW-1:0];
      r.volts = smooth;
      r.level = level;
      pending_readings.push_back(r);
    endfunction

    function int pending_count();
      return pending_readings.size();
    endfunction

    task report(string msg);
      mismatches++;
      $display("gauge mismatch: %s", msg);
    endtask

    task check_reading(logic [VoltW-1:0] volts, logic [LevelW-1:0] lvl);
      gauge_reading_t want;
      if (pending_readings.size() == 0) begin
        report($sformatf("reading %0d level %0d with nothing outstanding", volts, lvl));
        return;
      end
      want = pending_readings.pop_front();
      if (volts !== want.volts)
        report($sformatf("smoothed_voltage %0d, want %0d", volts, want.volts));
      if (lvl !== want.level)
        report($sformatf("charge_level %0d, want %0d (smoothed %0d)", lvl, want.level,
                         want.volts));
    endtask
  endclass

endpackage

@@ verif/tb_battery_voltage_smoother_level_gauge_core.sv @@
`timescale 1ns / 100ps
// testbench top for the battery voltage smoother and level gauge: directed and
// random sample streams across several threshold settings, random sender gaps,
// random receiver stalls; depends on bvslg_pkg, bvslg_tb_pkg and the gauge core
module tb_battery_voltage_smoother_level_gauge_core;
  import bvslg_pkg::*;
  import bvslg_tb_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic [IdxW-1:0]   cfg_index = '0;
  logic [VoltW-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [VoltW-1:0]  voltage_sample = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [VoltW-1:0]  smoothed_voltage;
  logic [LevelW-1:0] charge_level;

  level_gauge_checker chk;
  int                 burst_left = 0;
  int                 cycles = 0;
  stall_mode_t        stall_mode = STALL_NONE;
  int                 stall_hold = 0;

  battery_voltage_smoother_level_gauge_core u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .voltage_sample   (voltage_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .smoothed_voltage (smoothed_voltage),
    .charge_level     (charge_level)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver stall pattern, switches to a random mode whenever its hold runs out
  always @(posedge clk) begin
    if (stall_hold == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_hold <= $urandom_range(40, 300);
    end else begin
      stall_hold <= stall_hold - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= ((stall_hold % 7) < 3);
    endcase
  end

  // all ports sampled at the edge, before any nonblocking update lands
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write) chk.apply_reg(cfg_index, cfg_data);
      if (out_valid && !out_stall) chk.check_reading(smoothed_voltage, charge_level);
      if (in_valid && !in_stall) chk.note_sample(voltage_sample);
    end
  end

  // one sample transfer, then maybe close the burst with an idle gap
  task automatic stream_sample(input logic [VoltW-1:0] v);
    int gap;
    in_valid <= 1'b1;
    voltage_sample <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // hold off the sender until every outstanding reading has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chk.pending_count() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [VoltW-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic program_gauge(input int t1, input int t2, input int t3, input int t4,
                               input int hy, input int init_v, input bit poke_spare);
    settle();
    write_reg(REG_THR_ONE, VoltW'(t1));
    write_reg(REG_THR_TWO, VoltW'(t2));
    write_reg(REG_THR_THREE, VoltW'(t3));
    write_reg(REG_THR_FOUR, VoltW'(t4));
    write_reg(REG_HYST, VoltW'(hy));
    if (poke_spare) begin
      write_reg(REG_SPARE_LO, VoltW'($urandom));
      write_reg(REG_SPARE_HI, VoltW'($urandom));
    end
    write_reg(REG_INIT_VOLT, VoltW'(init_v));
    cfg_write <= 1'b0;
  endtask

  task automatic random_setting(input bit ascending);
    int t [$];
    int hy;
    for (int k = 0; k < 4; k++) t.push_back($urandom_range(0, 65535));
    if (ascending) t.sort();
    hy = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1000) : $urandom_range(0, 8191);
    program_gauge(t[0], t[1], t[2], t[3], hy, $urandom_range(0, 65535),
                  $urandom_range(0, 1));
  endtask

  // samples wander around one threshold at a time so the level crosses back
  // and forth; a share of full-range noise on top
  task automatic run_random(input int n, input int pause_at);
    int target;
    int v;
    for (int i = 0; i < n; i++) begin
      if (i == 0 || $urandom_range(0, 29) == 0) begin
        if ($urandom_range(0, 4) == 0) target = $urandom_range(0, 65535);
        else target = int'(chk.thr[$urandom_range(0, 3)]) + $urandom_range(0, 6000) - 3000;
      end
      if (i == pause_at) settle();
      if ($urandom_range(0, 9) < 2) begin
        v = $urandom_range(0, 65535);
      end else begin
        v = target + $urandom_range(0, 2000) - 1000;
        if (v < 0) v = 0;
        if (v > VOLT_CEIL) v = VOLT_CEIL;
      end
      stream_sample(VoltW'(v));
    end
  endtask

  initial begin
    logic [VoltW-1:0] directed [$];
    chk = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: climb to full, drop to empty, field extremes
    directed = {16'd0, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535,
                16'd65535, 16'd65535, 16'd65535, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                16'd99, 16'd100, 16'h5555, 16'hAAAA, 16'd47999, 16'd48000, 16'd50000,
                16'hFFFF};
    foreach (directed[k]) stream_sample(directed[k]);
    run_random(150, -1);

    // everything zero: level pinned at full
    program_gauge(0, 0, 0, 0, 0, 0, 1'b0);
    run_random(100, -1);

    // everything at the top: offset sums clamp, level pinned at empty
    program_gauge(65535, 65535, 65535, 65535, 8191, 65535, 1'b1);
    run_random(100, -1);

    // crowded near the top so threshold plus offset clamps for every level
    program_gauge(60000, 62000, 64000, 65000, 8191, 0, 1'b1);
    run_random(150, -1);

    // out of order thresholds, first match wins
    program_gauge(50000, 40000, 30000, 20000, 1000, 45000, 1'b0);
    run_random(150, -1);
    random_setting(1'b0);
    run_random(150, 75);

    for (int p = 0; p < 6; p++) begin
      random_setting(1'b1);
      run_random(150, -1);
    end

    settle();
    repeat (8) @(posedge clk);
    if (chk.mismatches == 0 && chk.pending_count() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/bvslg_pkg.sv
hdl/battery_voltage_smoother_level_gauge_core.sv
hdl/bvslg_checker.sv
verif/bvslg_tb_pkg.sv
verif/tb_battery_voltage_smoother_level_gauge_core.sv
